@@ hw/rtl/sttm_pkg.sv @@
// Package for the shadow taint tag memory: store geometry, register map,
// operation and packing codes, state machine type and the row control struct.
// No dependencies.
package sttm_pkg;

    // Tag store geometry: 4096 tag bytes kept as 512 rows of 8 bytes
    localparam int TAG_IDX_BITS      = 12;
    localparam int ROW_OFS_BITS      = 3;
    localparam int ROW_BYTES         = 1 << ROW_OFS_BITS;
    localparam int ROW_BITS          = 8 * ROW_BYTES;
    localparam int ROW_IDX_BITS      = TAG_IDX_BITS - ROW_OFS_BITS;
    localparam int ROW_DEPTH         = 1 << ROW_IDX_BITS;

    // Access geometry: up to 32 bytes, spanning at most five rows
    localparam int NBYTES_BITS       = 6;
    localparam int ROW_CNT_BITS      = 3;
    localparam int SIZE_CODE_MAX     = 5;

    localparam int DEFAULT_ADDR_BITS = 12;

    // Configuration port
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;
    localparam logic [0:0] REG_PACKING_MODE = 1'b0;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_BIT     = 2'd1,
        MODE_TWO_BIT = 2'd2
    } pack_mode_t;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } sttm_op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_DONE
    } sttm_state_t;

    // Control for one row of an access
    typedef struct packed {
        logic [ROW_OFS_BITS-1:0] ofs;
        logic [ROW_CNT_BITS-1:0] k;
        logic [NBYTES_BITS-1:0]  nbytes;
        logic [7:0]              mask;
        logic [7:0]              fill;
    } row_ctrl_t;

endpackage

@@ hw/rtl/sttm_req_if.sv @@
// Request channel of the shadow taint tag memory: valid/ready plus one access.
// Depends on sttm_pkg.
interface sttm_req_if #(
    parameter int ADDR_BITS = sttm_pkg::DEFAULT_ADDR_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [ADDR_BITS-1:0] address;
    logic [2:0]           size_code;
    logic                 new_label;

    modport source (
        output valid, operation, address, size_code, new_label,
        input  ready
    );

    modport sink (
        input  valid, operation, address, size_code, new_label,
        output ready
    );
endinterface

@@ hw/rtl/sttm_rsp_if.sv @@
// Response channel of the shadow taint tag memory: valid/ready plus the label.
// No dependencies.
interface sttm_rsp_if;
    logic valid;
    logic ready;
    logic label;

    modport source (
        output valid, label,
        input  ready
    );

    modport sink (
        input  valid, label,
        output ready
    );
endinterface

@@ hw/rtl/sttm_row_merge.sv @@
// Row merge unit: applies one access to one 8-byte row of the tag store,
// giving the merged row for a set and the any-tag hit for a get.
// Depends on sttm_pkg.
module sttm_row_merge (
    input  sttm_pkg::row_ctrl_t                ctrl,
    input  logic [sttm_pkg::ROW_BITS-1:0]      old_row,
    output logic [sttm_pkg::ROW_BITS-1:0]      new_row,
    output logic                               hit
);
    import sttm_pkg::*;

    logic [ROW_BYTES-1:0] byte_hit;

    // Per byte: is it covered, and which of its bits
    always_comb
    begin
        for (int j = 0; j < ROW_BYTES; j++)
        begin
            logic [NBYTES_BITS:0] pos;
            logic                 covered;
            logic [7:0]           m;
            logic [7:0]           old_b;
            pos     = (NBYTES_BITS+1)'({ctrl.k, ROW_OFS_BITS'(j)})
                      - (NBYTES_BITS+1)'(ctrl.ofs);
            covered = !pos[NBYTES_BITS] && (pos[NBYTES_BITS-1:0] < ctrl.nbytes);
            m       = covered ? ctrl.mask : 8'h00;
            old_b   = old_row[8*j +: 8];
            new_row[8*j +: 8] = (old_b & ~m) | (ctrl.fill & m);
            byte_hit[j]       = |(old_b & m);
        end
    end

    assign hit = |byte_hit;

endmodule

@@ hw/rtl/shadow_taint_tag_memory.sv @@
// Shadow taint tag memory: top level with the tag store, access planner,
// row sequencer, result register and configuration port.
// Depends on sttm_pkg, sttm_req_if, sttm_rsp_if and sttm_row_merge.
//
// Usage
//   req : get/set items (operation, address, size_code, new_label), valid/ready.
//   rsp : one label item per get, none per set, valid/ready.
//   APB : packing_mode at byte address 0; write it only while idle (unenforced).
// Sequencing
//   The store is 512 rows of 8 tag bytes in a dual-port RAM with a registered
//   read port. An access covers 1 to 5 rows; each row is read and merged, and
//   for a set written back, while the next row's read is issued. After the
//   last row a get moves to ST_DONE, which registers its label. A new item is
//   taken only in ST_IDLE, once the previous one is through.
// Reset
//   After rst_n the block sweeps all 512 RAM rows to zero, one row a cycle;
//   req.ready stays low meanwhile. packing_mode resets to 0.
// Stall
//   A finished get label sits in an output register; new items are taken while
//   it waits. A later get holds in its last state until that register drains.
module shadow_taint_tag_memory #(
    parameter int ADDR_BITS = sttm_pkg::DEFAULT_ADDR_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    sttm_req_if.sink                            req,
    sttm_rsp_if.source                          rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sttm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [sttm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [sttm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import sttm_pkg::*;

    localparam int EXT_BITS = (ADDR_BITS > TAG_IDX_BITS + 3) ? ADDR_BITS : TAG_IDX_BITS + 3;

    // Tag store
    logic [ROW_BITS-1:0] mem [ROW_DEPTH];

    logic                    rd_en;
    logic [ROW_IDX_BITS-1:0] rd_addr;
    logic [ROW_BITS-1:0]     rd_data_reg;
    logic                    wr_en;
    logic [ROW_IDX_BITS-1:0] wr_addr;
    logic [ROW_BITS-1:0]     wr_data;

    // Control and plan registers
    sttm_state_t             state_reg, state_next;
    logic [ROW_IDX_BITS-1:0] clr_row_reg, clr_row_next;
    logic [1:0]              mode_reg;
    logic                    res_valid_reg, res_valid_next;
    logic                    res_label_reg, res_label_next;
    logic                    op_reg;
    logic [ROW_IDX_BITS-1:0] base_row_reg;
    logic [ROW_OFS_BITS-1:0] ofs_reg;
    logic [NBYTES_BITS-1:0]  nbytes_reg;
    logic [7:0]              mask_reg;
    logic [7:0]              fill_reg;
    logic [ROW_CNT_BITS-1:0] last_reg;
    logic [ROW_CNT_BITS-1:0] k_reg, k_next;
    logic                    any_reg, any_next;

    // Planner outputs
    logic [EXT_BITS-1:0]     addr_ext;
    logic [2:0]              code_c;
    logic [TAG_IDX_BITS-1:0] p_idx;
    logic [NBYTES_BITS-1:0]  p_nbytes;
    logic [7:0]              p_mask;
    logic [7:0]              p_fill;
    logic [NBYTES_BITS-1:0]  p_span;
    logic [7:0]              sub_bits;

    logic                    accept;
    row_ctrl_t               row_ctrl;
    logic [ROW_BITS-1:0]     merged_row;
    logic                    row_hit;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_BITS-1:2] == REG_PACKING_MODE)
                    ? APB_DATA_BITS'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BYTE;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[APB_ADDR_BITS-1:2] == REG_PACKING_MODE)
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    // Access planner: start tag index, byte count and first-byte mask
    always_comb
    begin
        addr_ext = EXT_BITS'(req.address);
        code_c   = (req.size_code > 3'(SIZE_CODE_MAX)) ? 3'(SIZE_CODE_MAX) : req.size_code;
        p_fill   = req.new_label ? 8'hFF : 8'h00;
        p_mask   = 8'hFF;
        sub_bits = 8'h00;
        case (mode_reg)
            MODE_BIT:
            begin
                p_idx = addr_ext[TAG_IDX_BITS+2:3];
                if (code_c <= 3'd2)
                begin
                    case (code_c)
                        3'd0:    sub_bits = 8'h01;
                        3'd1:    sub_bits = 8'h03;
                        default: sub_bits = 8'h0F;
                    endcase
                    p_mask   = 8'(16'(sub_bits) << addr_ext[2:0]);
                    p_nbytes = NBYTES_BITS'(1);
                end
                else
                begin
                    p_nbytes = NBYTES_BITS'(1) << (code_c - 3'd3);
                end
            end
            MODE_TWO_BIT:
            begin
                p_idx = addr_ext[TAG_IDX_BITS+1:2];
                if (code_c <= 3'd1)
                begin
                    sub_bits = (code_c == 3'd0) ? 8'h03 : 8'h0F;
                    p_mask   = 8'(16'(sub_bits) << {addr_ext[1:0], 1'b0});
                    p_nbytes = NBYTES_BITS'(1);
                end
                else
                begin
                    p_nbytes = NBYTES_BITS'(1) << (code_c - 3'd2);
                end
            end
            default:
            begin
                // byte per byte, also the unused mode code
                p_idx    = addr_ext[TAG_IDX_BITS-1:0];
                p_nbytes = NBYTES_BITS'(1) << code_c;
                p_fill   = {7'b0, req.new_label};
            end
        endcase
        p_span = NBYTES_BITS'(p_idx[ROW_OFS_BITS-1:0]) + p_nbytes - NBYTES_BITS'(1);
    end

    // Row merge
    assign row_ctrl = '{ofs: ofs_reg, k: k_reg, nbytes: nbytes_reg,
                        mask: mask_reg, fill: fill_reg};

    sttm_row_merge u_row_merge (
        .ctrl    (row_ctrl),
        .old_row (rd_data_reg),
        .new_row (merged_row),
        .hit     (row_hit)
    );

    // Sequencer: next state and RAM controls
    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        k_next         = k_reg;
        any_next       = any_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        res_label_next = res_label_reg;
        accept         = 1'b0;
        req.ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = base_row_reg + ROW_IDX_BITS'(k_reg) + ROW_IDX_BITS'(1);
        wr_en          = 1'b0;
        wr_addr        = base_row_reg + ROW_IDX_BITS'(k_reg);
        wr_data        = merged_row;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_row_reg;
                wr_data      = '0;
                clr_row_next = clr_row_reg + ROW_IDX_BITS'(1);
                if (clr_row_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                accept    = req.valid;
                rd_addr   = p_idx[TAG_IDX_BITS-1:ROW_OFS_BITS];
                if (req.valid)
                begin
                    rd_en      = 1'b1;
                    k_next     = '0;
                    any_next   = 1'b0;
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                wr_en    = (op_reg == OP_SET);
                any_next = any_reg | row_hit;
                if (k_reg == last_reg)
                begin
                    state_next = (op_reg == OP_SET) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    rd_en  = 1'b1;
                    k_next = k_reg + ROW_CNT_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || rsp.ready)
                begin
                    res_valid_next = 1'b1;
                    res_label_next = any_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.label = res_label_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and plan registers
    always_ff @(posedge clk)
    begin
        res_label_reg <= res_label_next;
        k_reg         <= k_next;
        any_reg       <= any_next;
        if (accept)
        begin
            op_reg       <= req.operation;
            base_row_reg <= p_idx[TAG_IDX_BITS-1:ROW_OFS_BITS];
            ofs_reg      <= p_idx[ROW_OFS_BITS-1:0];
            nbytes_reg   <= p_nbytes;
            mask_reg     <= p_mask;
            fill_reg     <= p_fill;
            last_reg     <= p_span[NBYTES_BITS-1:ROW_OFS_BITS];
        end
    end

    // Tag store RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ bench/shadow_taint_tag_memory_test.sv @@
// Self-checking testbench for shadow_taint_tag_memory: directed and random get/set items
// in every packing mode, checked against an in-bench model of the tag store.
// Depends on sttm_pkg, sttm_req_if, sttm_rsp_if and the block's RTL.
module shadow_taint_tag_memory_test;
    import sttm_pkg::*;

    localparam int ADDR_W          = DEFAULT_ADDR_BITS;
    localparam int TAG_DEPTH       = 1 << TAG_IDX_BITS;
    localparam int SETTLE_CYCLES   = 12;
    localparam int END_WAIT_LIMIT  = 20000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_ITEMS     = 150;
    localparam int HOLD_ITEMS      = 120;
    localparam int LONG_HOLD       = 400;

    // Register address and the code that the enum leaves unnamed
    localparam logic [APB_ADDR_BITS-1:0] PACKING_MODE_ADDR = APB_ADDR_BITS'(4 * REG_PACKING_MODE);
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Size codes
    localparam logic [2:0] SZ_1B   = 3'd0;
    localparam logic [2:0] SZ_2B   = 3'd1;
    localparam logic [2:0] SZ_4B   = 3'd2;
    localparam logic [2:0] SZ_8B   = 3'd3;
    localparam logic [2:0] SZ_16B  = 3'd4;
    localparam logic [2:0] SZ_32B  = 3'd5;
    localparam logic [2:0] SZ_OVER = 3'd6;
    localparam logic [2:0] SZ_TOP  = 3'd7;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    sttm_req_if #(.ADDR_BITS(ADDR_W)) req_ch ();
    sttm_rsp_if rsp_ch ();

    shadow_taint_tag_memory #(.ADDR_BITS(ADDR_W)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model state: tag store and packing mode
    logic [7:0] shadow_tags [TAG_DEPTH];
    logic [1:0] packing;
    logic       expected_labels [$];

    // Run control and statistics
    bit source_quiet;
    bit sink_quiet;
    int long_hold_cycles;
    int mismatches;
    int gets_sent;
    int sets_sent;
    int labels_checked;
    int labels_high;
    int apb_writes;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly short, a few long
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // Covered region of an access: nbytes whole tags from idx, or mask bits of tag idx
    function automatic void plan_access(input logic [ADDR_W-1:0] addr, input logic [2:0] code_in,
                                        output logic [TAG_IDX_BITS-1:0] idx,
                                        output logic [7:0] mask, output int nbytes);
        int code;
        int sh;
        int width;
        code = (int'(code_in) > SIZE_CODE_MAX) ? SIZE_CODE_MAX : int'(code_in);
        mask = 8'hFF;
        nbytes = 0;
        case (packing)
            MODE_BIT:
            begin
                idx = TAG_IDX_BITS'(addr >> 3);
                sh = int'(addr[2:0]);
                if (code <= 2)
                begin
                    width = 1 << code;
                    mask = 8'((((1 << width) - 1) << sh) & 'hFF);
                end
                else
                    nbytes = 1 << (code - 3);
            end
            MODE_TWO_BIT:
            begin
                idx = TAG_IDX_BITS'(addr >> 2);
                sh = 2 * int'(addr[1:0]);
                if (code <= 1)
                    mask = 8'((((code == 0) ? 'h3 : 'hF) << sh) & 'hFF);
                else
                    nbytes = 1 << (code - 2);
            end
            default:
            begin
                idx = TAG_IDX_BITS'(addr);
                nbytes = 1 << code;
            end
        endcase
    endfunction

    // Apply one accepted item to the model; a get queues its label
    function automatic void predict_access(input sttm_op_t op, input logic [ADDR_W-1:0] addr,
                                           input logic [2:0] code, input logic lab);
        logic [TAG_IDX_BITS-1:0] idx;
        logic [7:0] mask;
        logic [7:0] fill;
        logic any;
        int nbytes;
        plan_access(addr, code, idx, mask, nbytes);
        if (op == OP_GET)
        begin
            any = 1'b0;
            if (nbytes == 0)
                any = |(shadow_tags[idx] & mask);
            else
                for (int k = 0; k < nbytes; k++)
                    if (shadow_tags[idx + TAG_IDX_BITS'(k)] != 8'h00)
                        any = 1'b1;
            expected_labels.push_back(any);
        end
        else if (nbytes == 0)
        begin
            if (lab)
                shadow_tags[idx] = shadow_tags[idx] | mask;
            else
                shadow_tags[idx] = shadow_tags[idx] & ~mask;
        end
        else
        begin
            if (packing == MODE_BIT || packing == MODE_TWO_BIT)
                fill = lab ? 8'hFF : 8'h00;
            else
                fill = {7'b0, lab};
            for (int k = 0; k < nbytes; k++)
                shadow_tags[idx + TAG_IDX_BITS'(k)] = fill;
        end
    endfunction

    // Send one item with a random lead-in gap; prediction happens on acceptance
    task automatic send_access(input sttm_op_t op, input logic [ADDR_W-1:0] addr,
                               input logic [2:0] code, input logic lab);
        int gap;
        gap = 0;
        if (!source_quiet && $urandom_range(0, 99) < 35)
            gap = random_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid     = 1'b0;
            req_ch.operation = 1'($urandom);
            req_ch.address   = ADDR_W'($urandom);
            req_ch.size_code = 3'($urandom);
            req_ch.new_label = 1'($urandom);
        end
        @(negedge clk);
        req_ch.valid     = 1'b1;
        req_ch.operation = op;
        req_ch.address   = addr;
        req_ch.size_code = code;
        req_ch.new_label = lab;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_access(op, addr, code, lab);
        if (op == OP_GET)
            gets_sent++;
        else
            sets_sent++;
    endtask

    // Stop offering items, then wait for every expected label and the tail of any set
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_labels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write packing_mode over APB once idle, then read it back
    task automatic change_packing(input logic [1:0] mode);
        logic [APB_DATA_BITS-1:0] readback;
        wait_drained();
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = PACKING_MODE_ADDR;
        pwdata  = APB_DATA_BITS'(mode);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        packing = mode;
        apb_writes++;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== APB_DATA_BITS'(mode))
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("packing_mode readback: expected %0d, got %0h", mode, readback);
        end
    endtask

    // Receiver: random ready gaps, plus a long hold-off on request
    initial
    begin : output_sink
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles > 0)
            begin
                hold_left = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                gap_left--;
            end
            else if (!sink_quiet && $urandom_range(0, 99) < 30)
            begin
                rsp_ch.ready = 1'b0;
                gap_left = random_gap() - 1;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    // Result check against the oldest expected label
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_labels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected label item: got %b", rsp_ch.label);
            end
            else
            begin
                if (rsp_ch.label !== expected_labels[0])
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("label mismatch: expected %b, got %b",
                                 expected_labels[0], rsp_ch.label);
                end
                if (expected_labels[0])
                    labels_high++;
                labels_checked++;
                void'(expected_labels.pop_front());
            end
        end
    end

    // Byte per byte: clear state, wrap past the top, one-byte fill values
    task automatic test_byte_mode();
        change_packing(MODE_BYTE);
        send_access(OP_GET, 12'd0,    SZ_32B, 1'b0);
        send_access(OP_GET, 12'd4095, SZ_32B, 1'b1);
        send_access(OP_SET, 12'd4095, SZ_32B, 1'b1);
        send_access(OP_GET, 12'd31,   SZ_1B,  1'b0);
        send_access(OP_GET, 12'd30,   SZ_1B,  1'b0);
        send_access(OP_GET, 12'd4094, SZ_1B,  1'b1);
        send_access(OP_SET, 12'd0,    SZ_8B,  1'b0);
        send_access(OP_GET, 12'd0,    SZ_8B,  1'b0);
        send_access(OP_GET, 12'd4095, SZ_2B,  1'b0);
    endtask

    // Bit per byte: sub-byte masks, bits past the byte, whole-byte fills at the top address
    task automatic test_bit_mode();
        change_packing(MODE_BIT);
        send_access(OP_SET, 12'd7,    SZ_1B,  1'b1);
        send_access(OP_GET, 12'd6,    SZ_1B,  1'b0);
        send_access(OP_GET, 12'd6,    SZ_2B,  1'b0);
        send_access(OP_SET, 12'd6,    SZ_4B,  1'b0);
        send_access(OP_GET, 12'd7,    SZ_1B,  1'b0);
        send_access(OP_SET, 12'd4095, SZ_32B, 1'b1);
        send_access(OP_GET, 12'd4088, SZ_8B,  1'b0);
    endtask

    // Two bits per byte: pairs of bits, the top pair dropping bits, wide clears
    task automatic test_two_bit_mode();
        change_packing(MODE_TWO_BIT);
        send_access(OP_SET, 12'd3,    SZ_2B,  1'b1);
        send_access(OP_GET, 12'd2,    SZ_2B,  1'b0);
        send_access(OP_SET, 12'd3,    SZ_1B,  1'b0);
        send_access(OP_GET, 12'd0,    SZ_16B, 1'b0);
        send_access(OP_SET, 12'd4092, SZ_32B, 1'b0);
    endtask

    // Oversized size codes and the unused packing mode
    task automatic test_odd_codes();
        change_packing(MODE_BYTE);
        send_access(OP_GET, 12'd0,   SZ_TOP,  1'b0);
        send_access(OP_SET, 12'd64,  SZ_OVER, 1'b1);
        change_packing(MODE_UNUSED);
        send_access(OP_GET, 12'd64,  SZ_32B,  1'b0);
        send_access(OP_SET, 12'd100, SZ_4B,   1'b1);
    endtask

    // Random traffic in phases that cycle through the packing modes
    task automatic test_random_traffic();
        logic [1:0] mode;
        logic [ADDR_W-1:0] hot_base;
        logic [ADDR_W-1:0] addr;
        logic [2:0] code;
        sttm_op_t op;
        int r;
        for (int phase = 0; phase < 10; phase++)
        begin
            mode = (phase == 6) ? MODE_UNUSED : 2'(phase % 3);
            change_packing(mode);
            hot_base = ADDR_W'($urandom_range(0, TAG_DEPTH - 129));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0)
                begin
                    source_quiet = ($urandom_range(0, 3) == 0);
                    sink_quiet   = ($urandom_range(0, 3) == 0);
                end
                if (i % 75 == 74 && $urandom_range(0, 2) == 0)
                    wait_drained();
                op = ($urandom_range(0, 1) == 1) ? OP_SET : OP_GET;
                r = $urandom_range(0, 99);
                if (r < 40)
                    addr = ADDR_W'($urandom_range(0, TAG_DEPTH - 1));
                else if (r < 80)
                    addr = hot_base + ADDR_W'($urandom_range(0, 127));
                else if (r < 90)
                    addr = ADDR_W'($urandom_range(TAG_DEPTH - 32, TAG_DEPTH - 1));
                else
                    addr = ADDR_W'($urandom_range(0, 31));
                if ($urandom_range(0, 99) < 3)
                    code = ($urandom_range(0, 1) == 1) ? SZ_TOP : SZ_OVER;
                else
                    code = 3'($urandom_range(SZ_1B, SZ_32B));
                send_access(op, addr, code, 1'($urandom_range(0, 1)));
            end
        end
        source_quiet = 1'b0;
        sink_quiet   = 1'b0;
    endtask

    // Long receiver hold-off while items keep coming, then a full drain
    task automatic test_output_backpressure();
        sttm_op_t op;
        change_packing(MODE_BIT);
        source_quiet = 1'b1;
        long_hold_cycles = LONG_HOLD;
        for (int i = 0; i < HOLD_ITEMS; i++)
        begin
            op = ($urandom_range(0, 99) < 80) ? OP_GET : OP_SET;
            send_access(op, ADDR_W'($urandom), 3'($urandom_range(SZ_1B, SZ_32B)),
                        1'($urandom));
        end
        wait_drained();
        source_quiet = 1'b0;
    endtask

    // Overall limit
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Main sequence
    initial
    begin
        int waited;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_GET;
        req_ch.address = '0;
        req_ch.size_code = SZ_1B;
        req_ch.new_label = 1'b0;
        for (int i = 0; i < TAG_DEPTH; i++)
            shadow_tags[i] = 8'h00;
        packing = MODE_BYTE;
        source_quiet = 1'b0;
        sink_quiet = 1'b0;
        long_hold_cycles = 0;
        mismatches = 0;
        gets_sent = 0;
        sets_sent = 0;
        labels_checked = 0;
        labels_high = 0;
        apb_writes = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // store clearing pass: input held off until done
        do
            @(posedge clk);
        while (!req_ch.ready);

        test_byte_mode();
        test_bit_mode();
        test_two_bit_mode();
        test_odd_codes();
        test_random_traffic();
        test_output_backpressure();

        @(negedge clk);
        req_ch.valid = 1'b0;
        waited = 0;
        while (expected_labels.size() != 0 && waited < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_labels.size() != 0)
        begin
            mismatches++;
            $display("%0d expected labels never arrived", expected_labels.size());
        end

        $display("covered %0d gets and %0d sets over %0d mode writes (all modes, all sizes)",
                 gets_sent, sets_sent, apb_writes);
        $display("checked %0d labels (%0d high), %0d mismatches, incl. a long output hold-off",
                 labels_checked, labels_high, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
